// ----- design/trvg_pkg.sv -----
// Shared types, constants and a helper function of the trail ribbon vertex generator.
package trvg_pkg;

   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_FRAC_BITS  = 16;

   localparam int CNT_W   = 11;
   localparam int WIDTH_W = 31;
   localparam int POS_W   = 32;
   localparam int TV_W    = 17;
   localparam int CSR_W   = 3;

   localparam logic [CSR_W-1:0] CSR_FACING_MODE  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_RIBBON_WIDTH = 3'd1;
   localparam logic [CSR_W-1:0] CSR_POINT_COUNT  = 3'd2;
   localparam logic [CSR_W-1:0] CSR_CAMERA_X     = 3'd3;
   localparam logic [CSR_W-1:0] CSR_CAMERA_Y     = 3'd4;
   localparam logic [CSR_W-1:0] CSR_CAMERA_Z     = 3'd5;

   localparam logic [5:0] CROSS_LAST = 6'd6;
   localparam logic [5:0] SUMSQ_LAST = 6'd3;
   localparam logic [5:0] SQRT_LAST  = 6'd31;
   localparam logic [5:0] COMP_LAST  = 6'd2;
   localparam logic [5:0] DIV_STEPS  = 6'd32;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_HOLD,
      OP_TV_START,
      OP_TV_SAVE,
      OP_LOAD_DIR,
      OP_LOAD_RIGHT,
      OP_LOAD_VIEW,
      OP_SCALE,
      OP_SAVE_DS,
      OP_SAVE_VS,
      OP_CROSS,
      OP_SUMSQ,
      OP_SQRT_INIT,
      OP_SQRT,
      OP_DIV_MUL,
      OP_DIV_START,
      OP_OFF_STORE,
      OP_OFF_ZERO,
      OP_EMIT,
      OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] step;
      logic       use_held;
      logic       minus;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic eidx_zero;
      logic eidx_one;
      logic held_valid;
      logic scaled;
      logic sum_zero;
      logic div_busy;
   } status_type;

   // Splits a signed value into sign and magnitude.
   function automatic logic [64:0] to_sm(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      return {v[63], m};
   endfunction

endpackage

// ----- design/trvg_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, 32 quotient bits.
module trvg_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [33:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic [33:0] rem_ff;
   logic [31:0] quo_ff;
   logic [33:0] den_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [34:0] trial;
   logic [34:0] diff;
   logic        fits;

   // The caller guarantees that the upper half of the dividend is below the divisor.
   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= trvg_pkg::DIV_STEPS;
         rem_ff  <= {2'b00, dividend[63:32]};
         quo_ff  <= dividend[31:0];
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[33:0] : trial[33:0];
         quo_ff <= {quo_ff[30:0], fits};
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/trvg_ctrl.sv -----
// Controller state machine that sequences the ribbon datapath for each point.
module trvg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  trvg_pkg::status_type st,
   output trvg_pkg::cmd_type    cmd
);

   typedef enum logic [18:0] {
      S_IDLE    = 19'h00001,
      S_DECIDE  = 19'h00002,
      S_TV_WAIT = 19'h00004,
      S_LOAD_D  = 19'h00008,
      S_SCALE_D = 19'h00010,
      S_LOAD_V  = 19'h00020,
      S_SCALE_V = 19'h00040,
      S_CROSS   = 19'h00080,
      S_SCALE_C = 19'h00100,
      S_SUMSQ   = 19'h00200,
      S_CHECK   = 19'h00400,
      S_SQRT    = 19'h00800,
      S_DMUL    = 19'h01000,
      S_DSTART  = 19'h02000,
      S_DWAIT   = 19'h04000,
      S_EMIT_P  = 19'h08000,
      S_WAIT_P  = 19'h10000,
      S_EMIT_M  = 19'h20000,
      S_WAIT_M  = 19'h40000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       held_pass_ff, held_pass_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      held_pass_in = held_pass_ff;
      cmd          = '0;
      cmd.op       = trvg_pkg::OP_NONE;
      cmd.step     = cnt_ff;
      cmd.use_held = held_pass_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = trvg_pkg::OP_CAPTURE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.mode && st.eidx_zero) begin
               cmd.op   = trvg_pkg::OP_HOLD;
               state_in = S_IDLE;
            end else begin
               cmd.op   = trvg_pkg::OP_TV_START;
               state_in = S_TV_WAIT;
            end
         end
         S_TV_WAIT: begin
            if (!st.div_busy) begin
               cmd.op       = trvg_pkg::OP_TV_SAVE;
               held_pass_in = st.mode && st.eidx_one && st.held_valid;
               state_in     = S_LOAD_D;
            end
         end
         S_LOAD_D: begin
            if (st.mode) begin
               cmd.op   = trvg_pkg::OP_LOAD_DIR;
               state_in = S_SCALE_D;
            end else begin
               cmd.op   = trvg_pkg::OP_LOAD_RIGHT;
               state_in = S_SCALE_C;
            end
         end
         S_SCALE_D: begin
            if (st.scaled) begin
               cmd.op   = trvg_pkg::OP_SAVE_DS;
               state_in = S_LOAD_V;
            end else begin
               cmd.op = trvg_pkg::OP_SCALE;
            end
         end
         S_LOAD_V: begin
            cmd.op   = trvg_pkg::OP_LOAD_VIEW;
            state_in = S_SCALE_V;
         end
         S_SCALE_V: begin
            if (st.scaled) begin
               cmd.op   = trvg_pkg::OP_SAVE_VS;
               cnt_in   = '0;
               state_in = S_CROSS;
            end else begin
               cmd.op = trvg_pkg::OP_SCALE;
            end
         end
         S_CROSS: begin
            cmd.op = trvg_pkg::OP_CROSS;
            if (cnt_ff == trvg_pkg::CROSS_LAST) begin
               cnt_in   = '0;
               state_in = S_SCALE_C;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_SCALE_C: begin
            if (st.scaled) begin
               cnt_in   = '0;
               state_in = S_SUMSQ;
            end else begin
               cmd.op = trvg_pkg::OP_SCALE;
            end
         end
         S_SUMSQ: begin
            cmd.op = trvg_pkg::OP_SUMSQ;
            if (cnt_ff == trvg_pkg::SUMSQ_LAST) begin
               cnt_in   = '0;
               state_in = S_CHECK;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_CHECK: begin
            if (st.sum_zero) begin
               cmd.op   = trvg_pkg::OP_OFF_ZERO;
               state_in = S_EMIT_P;
            end else begin
               cmd.op   = trvg_pkg::OP_SQRT_INIT;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = trvg_pkg::OP_SQRT;
            if (cnt_ff == trvg_pkg::SQRT_LAST) begin
               cnt_in   = '0;
               state_in = S_DMUL;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_DMUL: begin
            cmd.op   = trvg_pkg::OP_DIV_MUL;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.op   = trvg_pkg::OP_DIV_START;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (!st.div_busy) begin
               cmd.op = trvg_pkg::OP_OFF_STORE;
               if (cnt_ff == trvg_pkg::COMP_LAST) begin
                  cnt_in   = '0;
                  state_in = S_EMIT_P;
               end else begin
                  cnt_in   = cnt_ff + 6'd1;
                  state_in = S_DMUL;
               end
            end
         end
         S_EMIT_P: begin
            cmd.op   = trvg_pkg::OP_EMIT;
            state_in = S_WAIT_P;
         end
         S_WAIT_P: begin
            if (rsp_ready) begin
               state_in = S_EMIT_M;
            end
         end
         S_EMIT_M: begin
            cmd.op    = trvg_pkg::OP_EMIT;
            cmd.minus = 1'b1;
            state_in  = S_WAIT_M;
         end
         S_WAIT_M: begin
            if (rsp_ready) begin
               if (held_pass_ff) begin
                  held_pass_in = 1'b0;
                  state_in     = S_LOAD_D;
               end else begin
                  cmd.op   = trvg_pkg::OP_COMMIT;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         held_pass_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         held_pass_ff <= held_pass_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_WAIT_P) || (state_ff == S_WAIT_M);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("result offered while a new point is being taken");

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECIDE))
      else $error("accepted point not followed by the decision step");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == trvg_pkg::OP_TV_START || cmd.op == trvg_pkg::OP_DIV_START) |-> !st.div_busy)
      else $error("divider started while busy");

endmodule

// ----- design/trvg_dp.sv -----
// Datapath: configuration, point state, vector scaling, cross product, root, divider, output.
module trvg_dp #(
   parameter int MAX_POINTS = trvg_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = trvg_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  trvg_pkg::cmd_type                cmd,
   output trvg_pkg::status_type             st,
   input  logic                             csr_write,
   input  logic [trvg_pkg::CSR_W-1:0]       csr_index,
   input  logic [31:0]                      csr_data,
   input  logic signed [trvg_pkg::POS_W-1:0] in_pos_x,
   input  logic signed [trvg_pkg::POS_W-1:0] in_pos_y,
   input  logic signed [trvg_pkg::POS_W-1:0] in_pos_z,
   input  logic signed [trvg_pkg::POS_W-1:0] in_right_x,
   input  logic signed [trvg_pkg::POS_W-1:0] in_right_y,
   input  logic signed [trvg_pkg::POS_W-1:0] in_right_z,
   output logic signed [trvg_pkg::POS_W-1:0] out_vert_x,
   output logic signed [trvg_pkg::POS_W-1:0] out_vert_y,
   output logic signed [trvg_pkg::POS_W-1:0] out_vert_z,
   output logic                             out_tex_u,
   output logic [trvg_pkg::TV_W-1:0]        out_tex_v,
   output logic                             out_run_last,
   output logic                             out_strip_end
);

   localparam logic [16:0] MAXP = 17'(MAX_POINTS);

   logic signed [31:0] p_ff[3], r_ff[3], prev_ff[3], held_ff[3], cam_ff[3];
   logic signed [31:0] ds_ff[3], vs_ff[3], off_ff[3], vert_ff[3];
   logic               a_sgn_ff[3];
   logic [63:0]        a_mag_ff[3];
   logic signed [63:0] prod_ff, acc_ff;
   logic [63:0]        sum_ff, sx_ff, sr_ff, sbit_ff;
   logic [trvg_pkg::TV_W-1:0]    tv_ff, tex_v_ff;
   logic                         mode_ff, held_valid_ff;
   logic [trvg_pkg::WIDTH_W-1:0] width_ff;
   logic [trvg_pkg::CNT_W-1:0]   count_ff, index_ff;
   logic                         tex_u_ff, run_last_ff, strip_end_ff;

   logic [trvg_pkg::CNT_W-1:0] cnt, cnt_m1, eidx;
   logic                       last;
   logic [63:0]                mx, mag_sel;
   logic                       shift_right, scaled;
   logic signed [31:0]         ma, mb;
   logic signed [63:0]         mul_res;
   logic [5:0]                 jw;
   logic [63:0]                sq_trial;
   logic                       div_start, div_busy;
   logic [63:0]                div_dividend;
   logic [33:0]                div_divisor;
   logic [31:0]                div_q;
   logic signed [31:0]         qs;
   logic signed [31:0]         pt[3];
   logic [1:0]                 comp;

   always_comb begin
      if (count_ff < 11'd2) begin
         cnt = 11'd2;
      end else if ({6'd0, count_ff} > MAXP) begin
         cnt = MAXP[10:0];
      end else begin
         cnt = count_ff;
      end
      cnt_m1 = cnt - 11'd1;
      eidx   = (index_ff >= cnt_m1) ? cnt_m1 : index_ff;
      last   = (eidx == cnt_m1);
   end

   always_comb begin
      mx = a_mag_ff[0];
      if (a_mag_ff[1] > mx) begin
         mx = a_mag_ff[1];
      end
      if (a_mag_ff[2] > mx) begin
         mx = a_mag_ff[2];
      end
   end

   // Block scaling brings the largest magnitude into [2^30, 2^31).
   assign shift_right = |mx[63:31];
   assign scaled      = (mx == 64'd0) || (!shift_right && mx[30]);

   assign comp = cmd.step[1:0];

   always_comb begin
      case (comp)
         2'd0:    mag_sel = a_mag_ff[0];
         2'd1:    mag_sel = a_mag_ff[1];
         2'd2:    mag_sel = a_mag_ff[2];
         default: mag_sel = '0;
      endcase
   end

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         trvg_pkg::OP_CROSS: begin
            case (cmd.step[2:0])
               3'd0: begin ma = ds_ff[1]; mb = vs_ff[2]; end
               3'd1: begin ma = ds_ff[2]; mb = vs_ff[1]; end
               3'd2: begin ma = ds_ff[2]; mb = vs_ff[0]; end
               3'd3: begin ma = ds_ff[0]; mb = vs_ff[2]; end
               3'd4: begin ma = ds_ff[0]; mb = vs_ff[1]; end
               3'd5: begin ma = ds_ff[1]; mb = vs_ff[0]; end
               default: begin ma = '0; mb = '0; end
            endcase
         end
         trvg_pkg::OP_SUMSQ: begin
            ma = signed'(mag_sel[31:0]);
            mb = signed'(mag_sel[31:0]);
         end
         trvg_pkg::OP_DIV_MUL: begin
            ma = signed'(mag_sel[31:0]);
            mb = signed'({1'b0, width_ff});
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign mul_res  = ma * mb;
   assign jw       = cmd.step - 6'd1;
   assign sq_trial = sr_ff + sbit_ff;
   assign qs       = signed'(div_q);

   assign div_start = (cmd.op == trvg_pkg::OP_TV_START) || (cmd.op == trvg_pkg::OP_DIV_START);

   always_comb begin
      if (cmd.op == trvg_pkg::OP_TV_START) begin
         div_dividend = 64'(eidx) << FRAC_BITS;
         div_divisor  = 34'(cnt_m1);
      end else begin
         div_dividend = 64'(prod_ff);
         div_divisor  = {sr_ff[32:0], 1'b0};
      end
   end

   trvg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt[i] = cmd.use_held ? held_ff[i] : p_ff[i];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         width_ff <= 31'd65536;
         count_ff <= 11'd2;
         for (int i = 0; i < 3; i++) begin
            cam_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            trvg_pkg::CSR_FACING_MODE:  mode_ff   <= csr_data[0];
            trvg_pkg::CSR_RIBBON_WIDTH: width_ff  <= csr_data[30:0];
            trvg_pkg::CSR_POINT_COUNT:  count_ff  <= csr_data[10:0];
            trvg_pkg::CSR_CAMERA_X:     cam_ff[0] <= signed'(csr_data);
            trvg_pkg::CSR_CAMERA_Y:     cam_ff[1] <= signed'(csr_data);
            trvg_pkg::CSR_CAMERA_Z:     cam_ff[2] <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // Strip state.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         held_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else if (cmd.op == trvg_pkg::OP_HOLD) begin
         index_ff      <= 11'd1;
         held_valid_ff <= 1'b1;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= p_ff[i];
            held_ff[i] <= p_ff[i];
         end
      end else if (cmd.op == trvg_pkg::OP_COMMIT) begin
         index_ff      <= last ? '0 : eidx + 11'd1;
         held_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= p_ff[i];
         end
      end
   end

   // Arithmetic working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         trvg_pkg::OP_CAPTURE: begin
            p_ff[0] <= in_pos_x;
            p_ff[1] <= in_pos_y;
            p_ff[2] <= in_pos_z;
            r_ff[0] <= in_right_x;
            r_ff[1] <= in_right_y;
            r_ff[2] <= in_right_z;
         end
         trvg_pkg::OP_TV_SAVE: begin
            tv_ff <= div_q[trvg_pkg::TV_W-1:0];
         end
         trvg_pkg::OP_LOAD_RIGHT: begin
            for (int i = 0; i < 3; i++) begin
               {a_sgn_ff[i], a_mag_ff[i]} <= trvg_pkg::to_sm(64'(r_ff[i]));
            end
         end
         trvg_pkg::OP_LOAD_DIR: begin
            for (int i = 0; i < 3; i++) begin
               {a_sgn_ff[i], a_mag_ff[i]} <= trvg_pkg::to_sm(64'(p_ff[i]) -
                  64'(cmd.use_held ? held_ff[i] : prev_ff[i]));
            end
         end
         trvg_pkg::OP_LOAD_VIEW: begin
            for (int i = 0; i < 3; i++) begin
               {a_sgn_ff[i], a_mag_ff[i]} <= trvg_pkg::to_sm(64'(pt[i]) - 64'(cam_ff[i]));
            end
         end
         trvg_pkg::OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               a_mag_ff[i] <= shift_right ? (a_mag_ff[i] >> 1) : (a_mag_ff[i] << 1);
            end
         end
         trvg_pkg::OP_SAVE_DS: begin
            for (int i = 0; i < 3; i++) begin
               ds_ff[i] <= a_sgn_ff[i] ? -signed'(a_mag_ff[i][31:0]) : signed'(a_mag_ff[i][31:0]);
            end
         end
         trvg_pkg::OP_SAVE_VS: begin
            for (int i = 0; i < 3; i++) begin
               vs_ff[i] <= a_sgn_ff[i] ? -signed'(a_mag_ff[i][31:0]) : signed'(a_mag_ff[i][31:0]);
            end
         end
         trvg_pkg::OP_CROSS: begin
            // Products are pipelined: each step folds in the product of the step before.
            if (cmd.step < trvg_pkg::CROSS_LAST) begin
               prod_ff <= mul_res;
            end
            if (cmd.step != 6'd0) begin
               if (!jw[0]) begin
                  acc_ff <= prod_ff;
               end else begin
                  case (jw[2:1])
                     2'd0: {a_sgn_ff[0], a_mag_ff[0]} <= trvg_pkg::to_sm(acc_ff - prod_ff);
                     2'd1: {a_sgn_ff[1], a_mag_ff[1]} <= trvg_pkg::to_sm(acc_ff - prod_ff);
                     2'd2: {a_sgn_ff[2], a_mag_ff[2]} <= trvg_pkg::to_sm(acc_ff - prod_ff);
                     default: ;
                  endcase
               end
            end
         end
         trvg_pkg::OP_SUMSQ: begin
            if (cmd.step < trvg_pkg::SUMSQ_LAST) begin
               prod_ff <= mul_res;
            end
            if (cmd.step == 6'd1) begin
               sum_ff <= 64'(prod_ff);
            end else if (cmd.step != 6'd0) begin
               sum_ff <= sum_ff + 64'(prod_ff);
            end
         end
         trvg_pkg::OP_SQRT_INIT: begin
            sx_ff   <= sum_ff;
            sr_ff   <= '0;
            sbit_ff <= 64'd1 << 62;
         end
         trvg_pkg::OP_SQRT: begin
            if (sx_ff >= sq_trial) begin
               sx_ff <= sx_ff - sq_trial;
               sr_ff <= (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
         trvg_pkg::OP_DIV_MUL: begin
            prod_ff <= mul_res;
         end
         trvg_pkg::OP_OFF_STORE: begin
            case (comp)
               2'd0: off_ff[0] <= a_sgn_ff[0] ? -qs : qs;
               2'd1: off_ff[1] <= a_sgn_ff[1] ? -qs : qs;
               2'd2: off_ff[2] <= a_sgn_ff[2] ? -qs : qs;
               default: ;
            endcase
         end
         trvg_pkg::OP_OFF_ZERO: begin
            for (int i = 0; i < 3; i++) begin
               off_ff[i] <= '0;
            end
         end
         trvg_pkg::OP_EMIT: begin
            for (int i = 0; i < 3; i++) begin
               vert_ff[i] <= cmd.minus ? pt[i] - off_ff[i] : pt[i] + off_ff[i];
            end
            tex_u_ff     <= cmd.minus;
            tex_v_ff     <= cmd.use_held ? '0 : tv_ff;
            run_last_ff  <= cmd.minus && !cmd.use_held;
            strip_end_ff <= cmd.minus && !cmd.use_held && last;
         end
         default: ;
      endcase
   end

   always_comb begin
      st            = '0;
      st.mode       = mode_ff;
      st.eidx_zero  = (eidx == 11'd0);
      st.eidx_one   = (eidx == 11'd1);
      st.held_valid = held_valid_ff;
      st.scaled     = scaled;
      st.sum_zero   = (sum_ff == 64'd0);
      st.div_busy   = div_busy;
   end

   assign out_vert_x    = vert_ff[0];
   assign out_vert_y    = vert_ff[1];
   assign out_vert_z    = vert_ff[2];
   assign out_tex_u     = tex_u_ff;
   assign out_tex_v     = tex_v_ff;
   assign out_run_last  = run_last_ff;
   assign out_strip_end = strip_end_ff;

endmodule

// ----- design/trail_ribbon_vertex_generator_unit.sv -----
// Top level of the trail ribbon vertex generator: controller, datapath and ports.
//
// Each accepted trail point yields two triangle-strip vertices (plus side first, then
// minus side), or none for the first point in camera-facing mode, whose two vertices
// then come ahead of the second point's. A point is worked on alone: the block takes
// the next word only after the last vertex of this one is taken. A held first point
// adds a second pass, and a first point in camera-facing mode is only captured and
// held. A zero side axis skips the root and the offset divisions. Most of the work
// lies in the shared divider, which yields one quotient bit per cycle for the texture
// v and for each of the three offset components, in the 32-step square root, and in
// block scaling, which moves a vector one bit per cycle. Each vertex waits for
// rsp_ready as long as the receiver stalls.
// Configuration writes are taken at any time and must only be made while idle.
module trail_ribbon_vertex_generator_unit #(
   parameter int MAX_POINTS = trvg_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = trvg_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [trvg_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [trvg_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [trvg_pkg::POS_W-1:0] req_pos_z,
   input  logic signed [trvg_pkg::POS_W-1:0] req_right_x,
   input  logic signed [trvg_pkg::POS_W-1:0] req_right_y,
   input  logic signed [trvg_pkg::POS_W-1:0] req_right_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [trvg_pkg::POS_W-1:0] rsp_vert_x,
   output logic signed [trvg_pkg::POS_W-1:0] rsp_vert_y,
   output logic signed [trvg_pkg::POS_W-1:0] rsp_vert_z,
   output logic                              rsp_tex_u,
   output logic [trvg_pkg::TV_W-1:0]         rsp_tex_v,
   output logic                              rsp_run_last,
   output logic                              rsp_strip_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [trvg_pkg::CSR_W-1:0]        csr_index,
   input  logic [31:0]                       csr_data
);

   trvg_pkg::cmd_type    cmd;
   trvg_pkg::status_type st;

   assign csr_ready = 1'b1;

   trvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   trvg_dp #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .in_pos_x      (req_pos_x),
      .in_pos_y      (req_pos_y),
      .in_pos_z      (req_pos_z),
      .in_right_x    (req_right_x),
      .in_right_y    (req_right_y),
      .in_right_z    (req_right_z),
      .out_vert_x    (rsp_vert_x),
      .out_vert_y    (rsp_vert_y),
      .out_vert_z    (rsp_vert_z),
      .out_tex_u     (rsp_tex_u),
      .out_tex_v     (rsp_tex_v),
      .out_run_last  (rsp_run_last),
      .out_strip_end (rsp_strip_end)
   );

endmodule

// ----- bench/trvg_checker.sv -----
// Checker for the trail ribbon vertex generator: predicts every vertex and compares.
module trvg_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [trvg_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [trvg_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [trvg_pkg::POS_W-1:0] req_pos_z,
   input  logic signed [trvg_pkg::POS_W-1:0] req_right_x,
   input  logic signed [trvg_pkg::POS_W-1:0] req_right_y,
   input  logic signed [trvg_pkg::POS_W-1:0] req_right_z,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [trvg_pkg::POS_W-1:0] rsp_vert_x,
   input  logic signed [trvg_pkg::POS_W-1:0] rsp_vert_y,
   input  logic signed [trvg_pkg::POS_W-1:0] rsp_vert_z,
   input  logic                              rsp_tex_u,
   input  logic [trvg_pkg::TV_W-1:0]         rsp_tex_v,
   input  logic                              rsp_run_last,
   input  logic                              rsp_strip_end,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [trvg_pkg::CSR_W-1:0]        csr_index,
   input  logic [31:0]                       csr_data,
   output int                                errors,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint vec3_type [3];

   typedef struct {
      logic signed [trvg_pkg::POS_W-1:0] x, y, z;
      logic                              u;
      logic [trvg_pkg::TV_W-1:0]         v;
      logic                              run_last, strip_end;
   } vertex_type;

   vertex_type vertex_q[$];

   logic                       facing;
   longint unsigned            width_q;
   logic [trvg_pkg::CNT_W-1:0] count_q;
   vec3_type                   camera;
   logic [trvg_pkg::CNT_W-1:0] pt_index;
   vec3_type                   prev_pos, held_pos;
   logic                       held_ok;

   function automatic longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // Shift magnitudes until the largest sits in [2^30, 2^31).
   function automatic void block_scale(input vec3_type c, output vec3_type o);
      longint unsigned m [3];
      longint unsigned mx;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magn(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o = '{0, 0, 0};
         return;
      end
      while (mx >= 64'h8000_0000) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < 64'h4000_0000) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) o[i] = c[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void axis_offset(input vec3_type a, output vec3_type off);
      vec3_type n;
      longint unsigned sum, len2, q;
      block_scale(a, n);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += magn(n[i]) * magn(n[i]);
      if (sum == 0) begin
         off = '{0, 0, 0};
         return;
      end
      len2 = 2 * int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (magn(n[i]) * width_q) / len2;
         off[i] = n[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   // Side axis that faces the camera: cross(direction, view), both block-scaled.
   function automatic void facing_offset(input vec3_type d, input vec3_type v,
                                         output vec3_type off);
      vec3_type ds, vs, c;
      block_scale(d, ds);
      block_scale(v, vs);
      c[0] = ds[1] * vs[2] - ds[2] * vs[1];
      c[1] = ds[2] * vs[0] - ds[0] * vs[2];
      c[2] = ds[0] * vs[1] - ds[1] * vs[0];
      axis_offset(c, off);
   endfunction

   function automatic void push_pair(vec3_type p, vec3_type off,
                                     logic [trvg_pkg::TV_W-1:0] tv, logic rl, logic se);
      vertex_type a, b;
      a.x = trvg_pkg::POS_W'(p[0] + off[0]);
      a.y = trvg_pkg::POS_W'(p[1] + off[1]);
      a.z = trvg_pkg::POS_W'(p[2] + off[2]);
      b.x = trvg_pkg::POS_W'(p[0] - off[0]);
      b.y = trvg_pkg::POS_W'(p[1] - off[1]);
      b.z = trvg_pkg::POS_W'(p[2] - off[2]);
      a.u = 1'b0;
      b.u = 1'b1;
      a.v = tv;
      b.v = tv;
      a.run_last = 1'b0;
      b.run_last = rl;
      a.strip_end = 1'b0;
      b.strip_end = se;
      vertex_q.push_back(a);
      vertex_q.push_back(b);
   endfunction

   function automatic void predict_point(vec3_type p, vec3_type r);
      int cnt, eidx;
      logic last, had_held;
      vec3_type off, d, v;
      logic [trvg_pkg::TV_W-1:0] tv;
      cnt = count_q;
      if (cnt < 2) cnt = 2;
      if (cnt > trvg_pkg::DEF_MAX_POINTS) cnt = trvg_pkg::DEF_MAX_POINTS;
      eidx = pt_index >= cnt - 1 ? cnt - 1 : pt_index;
      last = (eidx == cnt - 1);
      had_held = held_ok;
      held_ok = 1'b0;
      if (facing && eidx == 0) begin
         held_pos = p;
         prev_pos = p;
         held_ok = 1'b1;
         pt_index = 1;
         return;
      end
      if (facing) begin
         if (eidx == 1 && had_held) begin
            for (int i = 0; i < 3; i++) begin
               d[i] = p[i] - held_pos[i];
               v[i] = held_pos[i] - camera[i];
            end
            facing_offset(d, v, off);
            push_pair(held_pos, off, '0, 1'b0, 1'b0);
         end
         for (int i = 0; i < 3; i++) begin
            d[i] = p[i] - prev_pos[i];
            v[i] = p[i] - camera[i];
         end
         facing_offset(d, v, off);
      end else begin
         axis_offset(r, off);
      end
      tv = trvg_pkg::TV_W'((longint'(eidx) << trvg_pkg::DEF_FRAC_BITS) / (cnt - 1));
      push_pair(p, off, tv, 1'b1, last);
      prev_pos = p;
      pt_index = last ? '0 : trvg_pkg::CNT_W'(eidx + 1);
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         errors = 0;
         facing = 1'b0;
         width_q = 65536;
         count_q = 2;
         camera = '{0, 0, 0};
         pt_index = '0;
         prev_pos = '{0, 0, 0};
         held_pos = '{0, 0, 0};
         held_ok = 1'b0;
         vertex_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               trvg_pkg::CSR_FACING_MODE:  facing = csr_data[0];
               trvg_pkg::CSR_RIBBON_WIDTH: width_q = csr_data[30:0];
               trvg_pkg::CSR_POINT_COUNT:  count_q = csr_data[trvg_pkg::CNT_W-1:0];
               trvg_pkg::CSR_CAMERA_X:     camera[0] = longint'($signed(csr_data));
               trvg_pkg::CSR_CAMERA_Y:     camera[1] = longint'($signed(csr_data));
               trvg_pkg::CSR_CAMERA_Z:     camera[2] = longint'($signed(csr_data));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (vertex_q.size() == 0) begin
               report("unexpected word", rsp_vert_x, 0);
            end else begin
               e = vertex_q.pop_front();
               if (rsp_vert_x !== e.x) report("vert_x", rsp_vert_x, e.x);
               if (rsp_vert_y !== e.y) report("vert_y", rsp_vert_y, e.y);
               if (rsp_vert_z !== e.z) report("vert_z", rsp_vert_z, e.z);
               if (rsp_tex_u !== e.u) report("tex_u", rsp_tex_u, e.u);
               if (rsp_tex_v !== e.v) report("tex_v", rsp_tex_v, e.v);
               if (rsp_run_last !== e.run_last) report("run_last", rsp_run_last, e.run_last);
               if (rsp_strip_end !== e.strip_end)
                  report("strip_end", rsp_strip_end, e.strip_end);
            end
         end
         if (req_valid && req_ready)
            predict_point('{req_pos_x, req_pos_y, req_pos_z},
                          '{req_right_x, req_right_y, req_right_z});
      end
      pending = vertex_q.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, stimulus, receiver stalls and the final verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE = 800;
   localparam longint LIMIT = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [trvg_pkg::POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [trvg_pkg::POS_W-1:0] req_right_x = '0, req_right_y = '0, req_right_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [trvg_pkg::POS_W-1:0] rsp_vert_x, rsp_vert_y, rsp_vert_z;
   logic rsp_tex_u;
   logic [trvg_pkg::TV_W-1:0] rsp_tex_v;
   logic rsp_run_last, rsp_strip_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [trvg_pkg::CSR_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   int errors, pending;
   bit calm = 1'b0;
   bit hold_req = 1'b0;
   bit holding = 1'b0;
   longint cycles = 0;
   logic signed [31:0] walk [3];

   trail_ribbon_vertex_generator_unit u_top (.*);

   trvg_checker u_checker (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && !holding && (calm || $urandom_range(99) >= 24);

   // Long receiver hold-off while the sender keeps offering points.
   initial begin
      wait (hold_req);
      @(negedge clock);
      holding = 1'b1;
      repeat (3000) @(negedge clock);
      holding = 1'b0;
   end

   task automatic send_point(logic [31:0] px, py, pz, rx, ry, rz);
      int gap;
      gap = (!calm && $urandom_range(99) < 24) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pos_x = px;
      req_pos_y = py;
      req_pos_z = pz;
      req_right_x = rx;
      req_right_y = ry;
      req_right_z = rz;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      do @(negedge clock); while (pending != 0);
      // A held first point gives no word but may still be in progress.
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [trvg_pkg::CSR_W-1:0] idx, logic [31:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_axis();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 32'd0;
      if (pick < 30) return $urandom_range(0, 131072) - 65536;
      return $urandom();
   endfunction

   // Mostly a random walk so strips look like trails; some jumps and repeats.
   task automatic random_point();
      int pick;
      pick = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         if (pick < 10) walk[i] = $urandom();
         else if (pick >= 95) walk[i] = walk[i];
         else walk[i] = walk[i] + ($urandom_range(0, 1 << $urandom_range(4, 24))
                                   - (1 << 12));
      end
      send_point(walk[0], walk[1], walk[2], rand_axis(), rand_axis(), rand_axis());
   endtask

   task automatic random_config();
      int pick;
      csr_write(trvg_pkg::CSR_FACING_MODE,
                {16'($urandom_range(0, 65535)), 15'd0, 1'($urandom_range(1))});
      pick = $urandom_range(9);
      csr_write(trvg_pkg::CSR_RIBBON_WIDTH, pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF :
                pick < 5 ? $urandom_range(1 << 14, 1 << 20) : $urandom());
      pick = $urandom_range(9);
      csr_write(trvg_pkg::CSR_POINT_COUNT, pick == 0 ? 32'd1024 : pick == 1 ? $urandom() :
                pick == 2 ? 32'd0 : {16'($urandom_range(0, 65535)), 16'd0} |
                32'($urandom_range(2, 12)));
      pick = $urandom_range(3);
      csr_write(trvg_pkg::CSR_CAMERA_X,
                pick == 0 ? $urandom() : walk[0] + $urandom_range(0, 1 << 22));
      csr_write(trvg_pkg::CSR_CAMERA_Y,
                pick == 0 ? $urandom() : walk[1] - $urandom_range(0, 1 << 22));
      csr_write(trvg_pkg::CSR_CAMERA_Z,
                pick == 0 ? $urandom() : walk[2] + $urandom_range(0, 1 << 20));
   endtask

   initial begin
      walk = '{0, 0, 0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Supplied axis with reset settings: extreme position, then a zero axis.
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      wait_idle();
      // Widest ribbon, point count below range, extreme camera.
      csr_write(trvg_pkg::CSR_RIBBON_WIDTH, 32'h7FFF_FFFF);
      csr_write(trvg_pkg::CSR_POINT_COUNT, 32'd0);
      csr_write(trvg_pkg::CSR_CAMERA_X, 32'h8000_0000);
      csr_write(trvg_pkg::CSR_CAMERA_Y, 32'h7FFF_FFFF);
      csr_write(trvg_pkg::CSR_CAMERA_Z, 32'h0);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
      send_point(32'h4000_0000, 32'hC000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0);
      wait_idle();
      // Camera facing with count above range: a held first point, a repeated
      // point (zero direction) and a point at the camera (zero view).
      csr_write(trvg_pkg::CSR_POINT_COUNT, 32'h7FF);
      csr_write(trvg_pkg::CSR_CAMERA_X, 32'h0);
      csr_write(trvg_pkg::CSR_CAMERA_Y, 32'h0);
      csr_write(trvg_pkg::CSR_FACING_MODE, 32'h1);
      send_point(32'h0, 32'h0, 32'h0001_0000, 0, 0, 0);
      send_point(32'h0001_0000, 32'h0, 32'h0001_0000, 0, 0, 0);
      send_point(32'h0001_0000, 32'h0, 32'h0001_0000, 0, 0, 0);
      send_point(32'h0, 32'h0, 32'h0, 0, 0, 0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
      wait_idle();
      // Index already past a shrunken count, then a zero-width ribbon.
      csr_write(trvg_pkg::CSR_POINT_COUNT, 32'd3);
      csr_write(trvg_pkg::CSR_FACING_MODE, 32'h0);
      send_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'h0001_0000, 0, 0);
      wait_idle();
      csr_write(trvg_pkg::CSR_RIBBON_WIDTH, 32'h0);
      csr_write(trvg_pkg::CSR_FACING_MODE, 32'h1);
      send_point(32'h0, 32'h0001_0000, 32'h0, 0, 0, 0);
      send_point(32'h0002_0000, 32'h0001_0000, 32'h0, 0, 0, 0);
      send_point(32'h0003_0000, 32'h0005_0000, 32'h0, 0, 0, 0);
      wait_idle();
      // Held first point dropped by a switch to the supplied axis.
      csr_write(trvg_pkg::CSR_RIBBON_WIDTH, 32'h0002_0000);
      send_point(32'h0005_0000, 32'h0, 32'h0, 0, 0, 0);
      wait_idle();
      csr_write(trvg_pkg::CSR_FACING_MODE, 32'h0);
      send_point(32'h0006_0000, 32'h0, 32'h0, 0, 32'h0001_0000, 0);
      send_point(32'h0007_0000, 32'h0, 32'h0, 32'hFFFF_0000, 0, 0);
      wait_idle();

      for (int phase = 0; phase < 10; phase++) begin
         random_config();
         calm = (phase == 3);
         if (phase == 6) hold_req = 1'b1;
         repeat (38) random_point();
         wait_idle();
         calm = 1'b0;
      end

      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
